FILE: design/f2s_pkg.sv
// Package for the binary64 to binary32 round-up converter.
// Holds format constants and the operand class type; no dependencies.
package f2s_pkg;
  localparam int unsigned DBL_W = 64;
  localparam int unsigned SGL_W = 32;
  localparam logic [10:0] DBL_EXP_MAX = 11'h7FF;
  localparam logic [31:0] SGL_POS_INF = 32'h7F800000;
  localparam logic [31:0] SGL_NEG_MAX = 32'hFF7FFFFF;
  localparam logic [31:0] SGL_QNAN    = 32'h7FC00000;

  // Classification of an operand, decided in the input stage
  typedef enum logic [1:0] {
    CLS_FINITE = 2'd0,
    CLS_ZERO   = 2'd1,
    CLS_INF    = 2'd2,
    CLS_NAN    = 2'd3
  } cls_t;
endpackage

FILE: design/fp64_to_fp32_round_up_core.sv
// Top level of the binary64 to binary32 converter, rounding toward +infinity.
// Depends on f2s_pkg for format constants and the operand class type.
// An accepted item passes through the input register and then the result register.
// Throughput: one item per cycle; the pipeline advances whenever the result register
// is empty or being taken, so a stalled output only blocks once both stages are full.
// Reset: synchronous, active-low rst_n clears both valid flags; payload is not reset.
module fp64_to_fp32_round_up_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] double_bits
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [31:0] single_bits
);

  // Stage valids and payloads
  logic        s1_vld_r, s1_vld_nxt;
  logic [63:0] s1_dat_r;
  logic        s2_vld_r, s2_vld_nxt;
  logic [31:0] s2_dat_r, s2_dat_nxt;

  logic        adv2, adv1;

  // Advance the result stage when empty or drained; the input stage when it can move
  assign adv2      = !s2_vld_r || out_tready;
  assign adv1      = !s1_vld_r || adv2;
  assign in_tready = adv1;

  assign s1_vld_nxt = adv1 ? in_tvalid : s1_vld_r;
  assign s2_vld_nxt = adv2 ? s1_vld_r  : s2_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s2_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_tvalid) begin
      s1_dat_r <= in_tdata;
    end
    if (adv2 && s1_vld_r) begin
      s2_dat_r <= s2_dat_nxt;
    end
  end

  // Conversion datapath, between the input and result registers
  logic         sgn;
  logic [10:0]  bexp;
  logic [51:0]  frac;
  logic [52:0]  sig;
  f2s_pkg::cls_t cls;
  logic         tiny;       // biased exponent below 897, i.e. e < -126
  logic [7:0]   rsh;        // extra right shift for the subnormal range, clamped
  logic [52:0]  sig_sh;
  logic [52:0]  sticky_msk;
  logic         lost;
  logic [23:0]  kept;
  logic [24:0]  kept_up;
  logic [31:0]  bits;

  always_comb begin
    sgn  = s1_dat_r[63];
    bexp = s1_dat_r[62:52];
    frac = s1_dat_r[51:0];

    if (bexp == f2s_pkg::DBL_EXP_MAX) begin
      cls = (frac == '0) ? f2s_pkg::CLS_INF : f2s_pkg::CLS_NAN;
    end else if (bexp == 11'd0 && frac == '0) begin
      cls = f2s_pkg::CLS_ZERO;
    end else begin
      cls = f2s_pkg::CLS_FINITE;
    end

    sig  = {(bexp != 11'd0), frac};
    // Normal single range starts at biased double exponent 1023-126 = 897;
    // double subnormals behave as exponent 1.
    tiny = (bexp < 11'd897);
    if (!tiny) begin
      rsh = 8'd0;
    end else if (bexp == 11'd0) begin
      rsh = 8'd35;            // beyond 24: nothing kept
    end else if (bexp < 11'd872) begin
      rsh = 8'd35;
    end else begin
      rsh = 8'(11'd897 - bexp);
    end

    // Total shift 29 + rsh; keep 24 bits, everything below is sticky
    sig_sh     = sig >> (6'd29 + 6'(rsh));
    sticky_msk = ~(53'h1FFFFFFFFFFFFF << (6'd29 + 6'(rsh)));
    if (rsh >= 8'd24) begin
      sig_sh     = '0;
      sticky_msk = '1;
    end
    lost    = |(sig & sticky_msk);
    kept    = sig_sh[23:0];
    kept_up = {1'b0, kept} + 25'(lost && !sgn);

    // Exponent field plus kept significand; carry ripples into exponent naturally
    if (!tiny) begin
      bits = {1'b0, 8'(bexp - 11'd897), 23'd0} + {7'd0, kept_up};
    end else begin
      bits = {7'd0, kept_up};
    end

    case (cls)
      f2s_pkg::CLS_ZERO: s2_dat_nxt = {sgn, 31'd0};
      f2s_pkg::CLS_INF:  s2_dat_nxt = {sgn, f2s_pkg::SGL_POS_INF[30:0]};
      f2s_pkg::CLS_NAN:  s2_dat_nxt = {sgn, f2s_pkg::SGL_QNAN[30:0] | {8'd0, frac[51:29]}};
      f2s_pkg::CLS_FINITE: begin
        // Overflow: bexp above 1150 always overflows, which also covers the 8-bit exponent wrap,
        // and a rounding carry into the all-ones exponent is caught by the compare below.
        if (bexp > 11'd1150 || bits >= f2s_pkg::SGL_POS_INF) begin
          s2_dat_nxt = sgn ? f2s_pkg::SGL_NEG_MAX : f2s_pkg::SGL_POS_INF;
        end else begin
          s2_dat_nxt = {sgn, bits[30:0]};
        end
      end
      default: s2_dat_nxt = '0;
    endcase
  end

  assign out_tvalid = s2_vld_r;
  assign out_tdata  = s2_dat_r;

  // A held result must not change while the sink stalls
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");

  // An accepted item moves on from the input register into the result register when unstalled
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready ##1 out_tready ##0 s1_vld_r |=> out_tvalid)
    else $error("item lost between stages");

  // Input is refused only when both stages are full
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_vld_r && s2_vld_r)
    else $error("needless back-pressure");

endmodule
